// ===== src/sit_pkg.sv =====
// shared types, constants and helpers of the sorted index table engine
`default_nettype none

package sit_pkg;

  localparam int ENTRIES  = 64;
  localparam int KEY_BITS = 31;
  localparam int SLOT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DELETE  = 2'd1,
    ACT_LIST    = 2'd2,
    ACT_COMPACT = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_PRESENT    = 3'd1,
    ST_DELETED    = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_FULL       = 3'd4,
    ST_LIST_ENTRY = 3'd5,
    ST_LIST_EMPTY = 3'd6,
    ST_COMPACTED  = 3'd7
  } status_e;

  // what every cell of the chain does in a cycle
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_ROTATE,
    CM_SWAP,
    CM_FIX
  } cell_mode_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_PASS,
    SQ_SORT,
    SQ_FIX,
    SQ_RESP
  } seq_state_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       phase;
  } cell_ctl_t;

  // one index entry: occupied, deleted mark, data slot and key
  typedef struct packed {
    logic                vld;
    logic                del;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  localparam entry_t ENT_DEAD = '{vld: 1'b0, del: 1'b0, slot: '0, key: '0};
  localparam entry_t ENT_LIVE = '{vld: 1'b1, del: 1'b0, slot: '0, key: '0};

  // free or deleted entries sink to the top of the chain during compaction
  function automatic logic is_dead(entry_t e);
    return !e.vld || e.del;
  endfunction

endpackage

`default_nettype wire

// ===== src/sit_if.sv =====
// valid/ready channel interfaces for the request and result streams
`default_nettype none

interface sit_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [sit_pkg::KEY_BITS-1:0]  key;

  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

interface sit_out_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic [sit_pkg::KEY_BITS-1:0]  found_key;
  logic [sit_pkg::SLOT_W-1:0]    slot;
  logic [sit_pkg::CNT_W-1:0]     entry_total;
  logic                          last;

  modport source (output valid, output status, output found_key, output slot,
                  output entry_total, output last, input ready);
  modport sink   (input valid, input status, input found_key, input slot,
                  input entry_total, input last, output ready);
endinterface

`default_nettype wire

// ===== src/sit_cell.sv =====
// one storage cell of the index chain: rotate, odd-even swap or compaction fix-up
`default_nettype none

module sit_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sit_pkg::cell_ctl_t ctl_i,
  input  logic [sit_pkg::SLOT_W-1:0] idx_i,
  input  sit_pkg::entry_t    left_i,
  input  sit_pkg::entry_t    right_i,
  output sit_pkg::entry_t    ent_o
);

  logic                          vld_q;
  logic                          del_q;
  logic [sit_pkg::SLOT_W-1:0]    slot_q;
  logic [sit_pkg::KEY_BITS-1:0]  key_q;
  sit_pkg::entry_t               ent_q;
  sit_pkg::entry_t               ent_d;
  logic                          pair_left;
  logic                          take_right;
  logic                          take_left;

  assign ent_q = '{vld: vld_q, del: del_q, slot: slot_q, key: key_q};
  assign ent_o = ent_q;

  // rotate, fix-up, or swap a dead and a live entry in the phase's pair
  always_comb begin
    pair_left  = (idx_i[0] == ctl_i.phase);
    take_right = pair_left && sit_pkg::is_dead(ent_q) && !sit_pkg::is_dead(right_i);
    take_left  = !pair_left && sit_pkg::is_dead(left_i) && !sit_pkg::is_dead(ent_q);
    ent_d      = ent_q;
    case (ctl_i.mode)
      sit_pkg::CM_ROTATE: begin
        ent_d = right_i;
      end
      sit_pkg::CM_SWAP: begin
        if (take_right) begin
          ent_d = right_i;
        end else if (take_left) begin
          ent_d = left_i;
        end
      end
      sit_pkg::CM_FIX: begin
        ent_d.vld  = ent_q.vld && !ent_q.del;
        ent_d.del  = 1'b0;
        ent_d.slot = idx_i;
      end
      default: begin
        ent_d = ent_q;
      end
    endcase
  end

  // occupancy and deleted flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      del_q <= 1'b0;
    end else begin
      vld_q <= ent_d.vld;
      del_q <= ent_d.del;
    end
  end

  // key and slot payload
  always_ff @(posedge clk_i) begin
    slot_q <= ent_d.slot;
    key_q  <= ent_d.key;
  end

endmodule

`default_nettype wire

// ===== src/sit_seq.sv =====
// sequencer: pass control, stream edits at the chain head and the result register
`default_nettype none

module sit_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  sit_in_if.sink             in_i,
  sit_out_if.source          out_o,
  input  sit_pkg::entry_t    head_i,
  output sit_pkg::entry_t    tail_o,
  output sit_pkg::cell_ctl_t ctl_o
);

  sit_pkg::seq_state_e           state_q, state_d;
  sit_pkg::action_e              act_q, act_d;
  logic [sit_pkg::KEY_BITS-1:0]  key_q, key_d;
  logic [sit_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [sit_pkg::CNT_W-1:0]     count_q, count_d;
  logic [sit_pkg::CNT_W-1:0]     live_q, live_d;
  sit_pkg::entry_t               carry_q, carry_d;
  logic                          ins_q, ins_d;
  logic                          hit_q, hit_d;
  logic                          hit_del_q, hit_del_d;
  logic [sit_pkg::SLOT_W-1:0]    hit_slot_q, hit_slot_d;
  sit_pkg::entry_t               pend_q, pend_d;
  logic                          pend_vld_q, pend_vld_d;

  logic                          o_vld_q, o_vld_d;
  sit_pkg::status_e              o_status_q, res_status;
  logic [sit_pkg::KEY_BITS-1:0]  o_key_q, res_key;
  logic [sit_pkg::SLOT_W-1:0]    o_slot_q, res_slot;
  logic [sit_pkg::CNT_W-1:0]     o_total_q, res_total;
  logic                          o_last_q, res_last;

  logic                          pass_end;
  logic                          can_push;
  logic                          push;
  logic                          step;
  logic                          full;
  sit_pkg::entry_t               new_ent;

  assign pass_end = (cnt_q == sit_pkg::CNT_W'(sit_pkg::ENTRIES));
  assign can_push = !o_vld_q || out_o.ready;
  assign full     = (count_q == sit_pkg::CNT_W'(sit_pkg::ENTRIES));
  assign new_ent  = '{vld: 1'b1, del: 1'b0, slot: count_q[sit_pkg::SLOT_W-1:0], key: key_q};

  assign in_i.ready        = (state_q == sit_pkg::SQ_IDLE);
  assign out_o.valid       = o_vld_q;
  assign out_o.status      = o_status_q;
  assign out_o.found_key   = o_key_q;
  assign out_o.slot        = o_slot_q;
  assign out_o.entry_total = o_total_q;
  assign out_o.last        = o_last_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sit_pkg::SQ_IDLE: begin
        if (in_i.valid) begin
          if (sit_pkg::action_e'(in_i.action) == sit_pkg::ACT_COMPACT) begin
            state_d = sit_pkg::SQ_SORT;
          end else begin
            state_d = sit_pkg::SQ_PASS;
          end
        end
      end
      sit_pkg::SQ_PASS: begin
        if (pass_end) state_d = sit_pkg::SQ_RESP;
      end
      sit_pkg::SQ_SORT: begin
        if (pass_end) state_d = sit_pkg::SQ_FIX;
      end
      sit_pkg::SQ_FIX: begin
        state_d = sit_pkg::SQ_RESP;
      end
      sit_pkg::SQ_RESP: begin
        if (can_push) state_d = sit_pkg::SQ_IDLE;
      end
      default: begin
        state_d = sit_pkg::SQ_IDLE;
      end
    endcase
  end

  // datapath and chain control per state
  always_comb begin
    act_d      = act_q;
    key_d      = key_q;
    cnt_d      = cnt_q;
    count_d    = count_q;
    live_d     = live_q;
    carry_d    = carry_q;
    ins_d      = ins_q;
    hit_d      = hit_q;
    hit_del_d  = hit_del_q;
    hit_slot_d = hit_slot_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    ctl_o      = '{mode: sit_pkg::CM_HOLD, phase: cnt_q[0]};
    tail_o     = head_i;
    step       = 1'b0;
    push       = 1'b0;
    res_status = sit_pkg::ST_NOT_FOUND;
    res_key    = key_q;
    res_slot   = '0;
    res_total  = count_q;
    res_last   = 1'b1;

    case (state_q)
      sit_pkg::SQ_IDLE: begin
        if (in_i.valid) begin
          act_d      = sit_pkg::action_e'(in_i.action);
          key_d      = in_i.key;
          cnt_d      = '0;
          ins_d      = 1'b0;
          hit_d      = 1'b0;
          hit_del_d  = 1'b0;
          pend_vld_d = 1'b0;
        end
      end

      // one full rotation; entries leave at the head and re-enter at the tail
      sit_pkg::SQ_PASS: begin
        if (!pass_end) begin
          step = 1'b1;
          case (act_q)
            sit_pkg::ACT_INSERT: begin
              if (ins_q) begin
                tail_o  = carry_q;
                carry_d = head_i;
              end else if (head_i.vld && head_i.key == key_q) begin
                hit_d      = 1'b1;
                hit_slot_d = head_i.slot;
              end else if (!full && !hit_q && (!head_i.vld || head_i.key > key_q)) begin
                tail_o  = new_ent;
                carry_d = head_i;
                ins_d   = 1'b1;
              end
            end
            sit_pkg::ACT_DELETE: begin
              if (head_i.vld && head_i.key == key_q) begin
                hit_d      = 1'b1;
                hit_slot_d = head_i.slot;
                hit_del_d  = head_i.del;
                tail_o.del = 1'b1;
              end
            end
            sit_pkg::ACT_LIST: begin
              if (head_i.vld && !head_i.del) begin
                if (pend_vld_q) begin
                  if (can_push) begin
                    push       = 1'b1;
                    res_status = sit_pkg::ST_LIST_ENTRY;
                    res_key    = pend_q.key;
                    res_slot   = pend_q.slot;
                    res_last   = 1'b0;
                  end else begin
                    step = 1'b0;
                  end
                end
                if (step) begin
                  pend_d     = head_i;
                  pend_vld_d = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
          if (step) begin
            ctl_o.mode = sit_pkg::CM_ROTATE;
            cnt_d      = cnt_q + sit_pkg::CNT_W'(1);
          end
        end
      end

      // odd-even transposition moves dead entries above the live ones
      sit_pkg::SQ_SORT: begin
        if (!pass_end) begin
          ctl_o.mode = sit_pkg::CM_SWAP;
          cnt_d      = cnt_q + sit_pkg::CNT_W'(1);
        end
      end

      sit_pkg::SQ_FIX: begin
        ctl_o.mode = sit_pkg::CM_FIX;
      end

      sit_pkg::SQ_RESP: begin
        if (can_push) begin
          push = 1'b1;
          case (act_q)
            sit_pkg::ACT_INSERT: begin
              if (hit_q) begin
                res_status = sit_pkg::ST_PRESENT;
                res_slot   = hit_slot_q;
              end else if (full) begin
                res_status = sit_pkg::ST_FULL;
              end else begin
                res_status = sit_pkg::ST_INSERTED;
                res_slot   = count_q[sit_pkg::SLOT_W-1:0];
                res_total  = count_q + sit_pkg::CNT_W'(1);
                count_d    = count_q + sit_pkg::CNT_W'(1);
                live_d     = live_q + sit_pkg::CNT_W'(1);
              end
            end
            sit_pkg::ACT_DELETE: begin
              if (hit_q && !hit_del_q) begin
                res_status = sit_pkg::ST_DELETED;
                res_slot   = hit_slot_q;
                live_d     = live_q - sit_pkg::CNT_W'(1);
              end
            end
            sit_pkg::ACT_LIST: begin
              if (pend_vld_q) begin
                res_status = sit_pkg::ST_LIST_ENTRY;
                res_key    = pend_q.key;
                res_slot   = pend_q.slot;
              end else begin
                res_status = sit_pkg::ST_LIST_EMPTY;
                res_key    = '0;
              end
            end
            default: begin
              res_status = sit_pkg::ST_COMPACTED;
              res_key    = '0;
              res_total  = live_q;
              count_d    = live_q;
            end
          endcase
        end
      end

      default: begin
      end
    endcase
  end

  // result register empties on a transfer and refills on a push
  always_comb begin
    if (push) begin
      o_vld_d = 1'b1;
    end else if (out_o.ready) begin
      o_vld_d = 1'b0;
    end else begin
      o_vld_d = o_vld_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sit_pkg::SQ_IDLE;
      cnt_q      <= '0;
      count_q    <= '0;
      live_q     <= '0;
      ins_q      <= 1'b0;
      hit_q      <= 1'b0;
      hit_del_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      o_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      count_q    <= count_d;
      live_q     <= live_d;
      ins_q      <= ins_d;
      hit_q      <= hit_d;
      hit_del_q  <= hit_del_d;
      pend_vld_q <= pend_vld_d;
      o_vld_q    <= o_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    key_q      <= key_d;
    carry_q    <= carry_d;
    hit_slot_q <= hit_slot_d;
    pend_q     <= pend_d;
    if (push) begin
      o_status_q <= res_status;
      o_key_q    <= res_key;
      o_slot_q   <= res_slot;
      o_total_q  <= res_total;
      o_last_q   <= res_last;
    end
  end

endmodule

`default_nettype wire

// ===== src/sorted_index_table_engine.sv =====
// top level: sorted index kept in a chain of cells that rotates through one head
// results: insert, delete and compact each give one result after their pass over the chain;
//   list gives one per live entry or one if none, last flagged, holds the rotation on a stall
// pacing: a new request is taken only after the previous result is pushed, as each one
//   takes one full rotation, or one odd-even sort sweep and a fix-up, over the cell chain
// reset: entry count, live count and all occupancy and deleted flags clear at once;
//   keys and slots stay unset, there is no clearing pass
`default_nettype none

module sorted_index_table_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  sit_in_if.sink     in_i,
  sit_out_if.source  out_o
);

  sit_pkg::entry_t    ent [sit_pkg::ENTRIES];
  sit_pkg::entry_t    tail;
  sit_pkg::entry_t    last_right;
  sit_pkg::cell_ctl_t ctl;

  // sequencer works on the head cell and feeds the tail cell
  sit_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .head_i (ent[0]),
    .tail_o (tail),
    .ctl_o  (ctl)
  );

  // the tail cell sees the sequencer stream only while rotating
  assign last_right = (ctl.mode == sit_pkg::CM_ROTATE) ? tail : sit_pkg::ENT_DEAD;

  // cell chain
  for (genvar gi = 0; gi < sit_pkg::ENTRIES; gi++) begin : g_cell
    sit_pkg::entry_t left_w;
    sit_pkg::entry_t right_w;

    if (gi == 0) begin : g_first
      assign left_w = sit_pkg::ENT_LIVE;
    end else begin : g_mid_l
      assign left_w = ent[gi-1];
    end

    if (gi == sit_pkg::ENTRIES - 1) begin : g_last
      assign right_w = last_right;
    end else begin : g_mid_r
      assign right_w = ent[gi+1];
    end

    sit_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .idx_i   (sit_pkg::SLOT_W'(gi)),
      .left_i  (left_w),
      .right_i (right_w),
      .ent_o   (ent[gi])
    );
  end

  // a transfer in starts work, so the next cycle takes nothing
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while an item is still in progress");

  // the chain stands still whenever the block waits for input
  a_chain_quiet_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (ctl.mode == sit_pkg::CM_HOLD))
    else $error("cell chain moves while idle");

  // only list entries can be followed by more results
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status != sit_pkg::ST_LIST_ENTRY)) |-> out_o.last)
    else $error("single-result action without last flag");

  // at rest the occupied entries sit at the bottom of the chain
  a_packed_at_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.ready && ent[1].vld) |-> ent[0].vld)
    else $error("index entries not packed from the head");

endmodule

`default_nettype wire
